@@ design/pte_pkg.sv @@
`default_nettype none
package pte_pkg;

  // Default number of page tables in the pool.
  localparam int POOL_TABLES_DEF   = 16;
  // Entries in one page table and in the directory.
  localparam int ENTRIES_PER_TABLE = 1024;
  localparam int IDX_W             = 10;
  localparam int DIR_SHIFT         = 22;
  localparam int TBL_SHIFT         = 12;
  localparam int OFFSET_W          = 12;

  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 32;
  localparam int FLAGS_W  = 12;
  localparam int STATUS_W = 2;

  // Bit positions of the flag field.
  localparam int FLAG_PRESENT_BIT = 0;
  localparam int FLAG_USER_BIT    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_MAP   = 2'd0,
    CMD_UNMAP = 2'd1,
    CMD_XLATE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_TABLE   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_MAPPED = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIR,
    ST_TBL,
    ST_RESP
  } state_t;

endpackage
`default_nettype wire

@@ design/pte_if.sv @@
`default_nettype none
interface pte_in_if;
  logic                       valid;
  logic                       ready;
  logic [pte_pkg::CMD_W-1:0]   command;
  logic [pte_pkg::ADDR_W-1:0]  virt_addr;
  logic [pte_pkg::ADDR_W-1:0]  phys_addr;
  logic [pte_pkg::FLAGS_W-1:0] entry_flags;

  modport source (output valid, command, virt_addr, phys_addr, entry_flags, input ready);
  modport sink   (input valid, command, virt_addr, phys_addr, entry_flags, output ready);
endinterface

interface pte_out_if;
  logic                        valid;
  logic                        ready;
  logic [pte_pkg::STATUS_W-1:0] status;
  logic [pte_pkg::ADDR_W-1:0]   translated_addr;

  modport source (output valid, status, translated_addr, input ready);
  modport sink   (input valid, status, translated_addr, output ready);
endinterface
`default_nettype wire

@@ design/pte_ram.sv @@
`default_nettype none
module pte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ design/two_level_page_table_engine_unit.sv @@
`default_nettype none
// Two-level page table engine. The directory (1024 entries) and the pool of
// POOL_TABLES page tables (1024 entries each) sit in two synchronous RAMs.
// Each command transfer walks directory then table: the directory read goes
// out with the input transfer, map and unmap then write the table entry (and
// the directory entry on allocation or user promotion) in the directory
// state, and translate takes the table entry in a further table state. One
// result transfer follows each command. The result passes from the directory
// state (and the table state for translate) through the result state into
// the output register, and the next command transfer waits until it has been
// handed over. A result held in the output register stalls the engine in its
// result state until the receiver takes it. One command is worked on at a time.
// Tables are handed out in order and never freed; map answers "no free page
// table" once the pool is used up. After reset the engine zeroes both RAMs,
// one table entry per cycle, across all POOL_TABLES * 1024 table entries,
// before it takes its first command.
module two_level_page_table_engine_unit #(
  parameter int POOL_TABLES = pte_pkg::POOL_TABLES_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  pte_in_if.sink    in_ch,
  pte_out_if.source out_ch
);
  import pte_pkg::*;

  localparam int TW        = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
  localparam int CW        = $clog2(POOL_TABLES + 1);
  localparam int DE_W      = TW + 2;
  localparam int TBL_DEPTH = POOL_TABLES * ENTRIES_PER_TABLE;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int DIR_AW    = $clog2(ENTRIES_PER_TABLE);

  // Engine control.
  state_t              state_r, state_nxt;
  logic [TBL_AW-1:0]   clr_r, clr_nxt;
  logic [CW-1:0]       nft_r, nft_nxt;

  // Command captured at the input transfer.
  cmd_t                cmd_r;
  logic [ADDR_W-1:0]   va_r;
  logic [ADDR_W-1:0]   pa_r;
  logic [FLAGS_W-1:0]  fl_r;

  // Result waiting for the output register.
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;

  // RAM ports.
  logic                dir_we;
  logic [DIR_AW-1:0]   dir_waddr;
  logic [DE_W-1:0]     dir_wdata;
  logic [DIR_AW-1:0]   dir_raddr;
  logic [DE_W-1:0]     dir_rdata;
  logic                tbl_we;
  logic [TBL_AW-1:0]   tbl_waddr;
  logic [ADDR_W-1:0]   tbl_wdata;
  logic [TBL_AW-1:0]   tbl_raddr;
  logic [ADDR_W-1:0]   tbl_rdata;

  logic                in_xfer;
  logic                de_present;
  logic [TW-1:0]       de_tnum;
  logic [TW-1:0]       new_tnum;
  logic                pool_full;
  logic [IDX_W-1:0]    tidx;
  logic [ADDR_W-1:0]   map_entry;

  pte_ram #(.WIDTH(DE_W), .DEPTH(ENTRIES_PER_TABLE)) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  pte_ram #(.WIDTH(ADDR_W), .DEPTH(TBL_DEPTH)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign in_xfer               = in_ch.valid && in_ch.ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.translated_addr = out_addr_r;

  // Directory read goes out straight from the input transfer.
  assign dir_raddr = in_ch.virt_addr[DIR_SHIFT +: IDX_W];

  assign de_present = dir_rdata[0];
  assign de_tnum    = dir_rdata[DE_W-1:2];
  assign new_tnum   = TW'(nft_r);
  assign pool_full  = (nft_r == CW'(POOL_TABLES));
  assign tidx       = va_r[TBL_SHIFT +: IDX_W];
  assign map_entry  = {pa_r[ADDR_W-1:OFFSET_W], fl_r};
  assign tbl_raddr  = TBL_AW'({de_tnum, tidx});

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    nft_nxt        = nft_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    dir_we         = 1'b0;
    dir_waddr      = va_r[DIR_SHIFT +: IDX_W];
    dir_wdata      = '0;
    tbl_we         = 1'b0;
    tbl_waddr      = TBL_AW'({de_tnum, tidx});
    tbl_wdata      = '0;

    unique case (state_r)
      ST_CLEAR: begin
        // Sweep zeros through both RAMs; the directory wraps on the low bits.
        dir_we    = 1'b1;
        dir_waddr = clr_r[DIR_AW-1:0];
        tbl_we    = 1'b1;
        tbl_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == TBL_AW'(TBL_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_DIR;
        end
      end
      ST_DIR: begin
        res_status_nxt = STAT_OK;
        res_addr_nxt   = '0;
        state_nxt      = ST_RESP;
        unique case (cmd_r)
          CMD_MAP: begin
            if (!de_present) begin
              if (pool_full) begin
                res_status_nxt = STAT_NO_TABLE;
              end else begin
                // Take the next pool table; it is still all zero from reset.
                dir_we    = 1'b1;
                dir_wdata = {new_tnum, fl_r[FLAG_USER_BIT], 1'b1};
                tbl_we    = 1'b1;
                tbl_waddr = TBL_AW'({new_tnum, tidx});
                tbl_wdata = map_entry;
                nft_nxt   = nft_r + 1'b1;
              end
            end else begin
              // Promote the user flag into the directory entry.
              if (fl_r[FLAG_USER_BIT]) begin
                dir_we    = 1'b1;
                dir_wdata = dir_rdata | DE_W'(2);
              end
              tbl_we    = 1'b1;
              tbl_wdata = map_entry;
            end
          end
          CMD_UNMAP: begin
            tbl_we = de_present;
          end
          CMD_XLATE: begin
            if (de_present) begin
              state_nxt = ST_TBL;
            end else begin
              res_status_nxt = STAT_NOT_MAPPED;
            end
          end
          default: begin
          end
        endcase
      end
      ST_TBL: begin
        state_nxt = ST_RESP;
        if (tbl_rdata[FLAG_PRESENT_BIT]) begin
          res_addr_nxt = {tbl_rdata[ADDR_W-1:OFFSET_W], va_r[OFFSET_W-1:0]};
        end else begin
          res_status_nxt = STAT_NOT_MAPPED;
        end
      end
      ST_RESP: begin
        // Hold until the output register is free, then hand the result over.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      nft_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      nft_r       <= nft_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r <= cmd_t'(in_ch.command);
      va_r  <= in_ch.virt_addr;
      pa_r  <= in_ch.phys_addr;
      fl_r  <= in_ch.entry_flags;
    end
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

endmodule
`default_nettype wire
